### rtl/nne_pkg.sv
// ----------------------------------------------------------------------------
// nne_pkg
// Shared types, codes, constants and arithmetic helpers of the neuron
// network Euler step block.
// ----------------------------------------------------------------------------
`default_nettype none

package nne_pkg;

	localparam int NEURONS         = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int NIDX_W          = $clog2(NEURONS);
	localparam int WADDR_W         = 2 * NIDX_W;
	localparam int ROM_IDX_W       = $clog2(EXP_TABLE_DEPTH);
	localparam int ACC_W           = 41 + NIDX_W + 1;
	localparam int CFG_IDX_W       = 3;
	localparam logic signed [31:0] X_LIMIT = 32'sd524288;
	localparam logic [63:0] EINV_Q32 = 64'd1580030169;
	localparam int SERIES_TERMS    = 13;

	localparam logic [2:0] ACT_GAP     = 3'd0;
	localparam logic [2:0] ACT_SYN     = 3'd1;
	localparam logic [2:0] ACT_PARAM   = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_TICK    = 3'd4;

	localparam logic [2:0] PSEL_INV_RES  = 3'd0;
	localparam logic [2:0] PSEL_INV_CAP  = 3'd1;
	localparam logic [2:0] PSEL_REVERSAL = 3'd2;
	localparam logic [2:0] PSEL_MIDPOINT = 3'd3;
	localparam logic [2:0] PSEL_INIT_V   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_COND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYN_GMAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK_POT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_SLOPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd4;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_G_DIFF, S_G_MUL1, S_G_ROM, S_G_MUL2, S_G_STORE,
		S_L_DIFF, S_L_MUL, S_L_STORE,
		S_P_DIFF, S_P_MULG, S_P_MULS, S_P_ACCS,
		S_T_SUM, S_T_MUL1, S_T_MUL2, S_T_STORE,
		S_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_ACCEPT,
		OP_G_DIFF, OP_G_MUL1, OP_G_ROM, OP_G_MUL2, OP_G_STORE,
		OP_L_DIFF, OP_L_MUL, OP_L_STORE,
		OP_P_DIFF, OP_P_MULG, OP_P_MULS, OP_P_ACCS,
		OP_T_SUM, OP_T_MUL1, OP_T_MUL2, OP_T_STORE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [NIDX_W-1:0] i;
		logic [NIDX_W-1:0] j;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	typedef logic [31:0] sig_rom_t [EXP_TABLE_DEPTH];

	function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
		return {{32{a[31]}}, a};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] mulq_rnd(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd32768) >>> 16;
		return sat32(t);
	endfunction

	// shift-subtract quotient, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid 1/(1+exp(x)) in Q16.16 over x in [-8,8]
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t   rom;
		logic signed [63:0] x;
		logic [63:0] y, f, sum, term, den, num;
		int unsigned n;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			x = -64'sd524288 + $signed(udiv64(64'd1048576 * 64'(k),
				64'(EXP_TABLE_DEPTH - 1)));
			y = (x < 0) ? 64'(-x) : 64'(x);
			f = (y & 64'hffff) << 16;
			n = 32'((y >> 16) & 64'd15);
			sum = 64'd1 << 32;
			term = 64'd1 << 32;
			for (int kk = 1; kk <= SERIES_TERMS; kk++) begin
				term = udiv64((term * f) >> 32, 64'(kk));
				if (kk[0])
					sum = sum - term;
				else
					sum = sum + term;
			end
			for (int m = 0; m < 16; m++)
				if (m < n)
					sum = (sum * EINV_Q32) >> 32;
			den = (64'd1 << 32) + sum;
			num = (x >= 0) ? (sum << 16) : (64'd1 << 48);
			rom[k] = 32'(udiv64(num + (den >> 1), den));
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

### rtl/nne_ram.sv
// ----------------------------------------------------------------------------
// nne_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

### rtl/nne_ctrl.sv
// ----------------------------------------------------------------------------
// nne_ctrl
// Sequencer: weight clear sweep, item acceptance and the tick schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module nne_ctrl import nne_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [2:0] action,
	output logic            item_stall,
	output dp_cmd_t         cmd,
	input  wire dp_sts_t    sts
);

	localparam logic [NIDX_W-1:0] LAST = NIDX_W'(NEURONS - 1);

	state_t state_q, state_d;
	logic [NIDX_W-1:0] i_q, j_q, i_d, j_d;
	logic i_last, j_last;

	assign i_last = (i_q == LAST);
	assign j_last = (j_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		unique case (state_q)
			S_CLEAR: begin
				j_d = j_last ? '0 : j_q + 1'b1;
				if (j_last) begin
					i_d = i_last ? '0 : i_q + 1'b1;
					if (i_last)
						state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				i_d = '0;
				j_d = '0;
				if (item_valid && action == ACT_TICK)
					state_d = S_G_DIFF;
			end
			S_G_DIFF:  state_d = S_G_MUL1;
			S_G_MUL1:  state_d = S_G_ROM;
			S_G_ROM:   state_d = S_G_MUL2;
			S_G_MUL2:  state_d = S_G_STORE;
			S_G_STORE: begin
				j_d = j_last ? '0 : j_q + 1'b1;
				state_d = j_last ? S_L_DIFF : S_G_DIFF;
			end
			S_L_DIFF:  state_d = S_L_MUL;
			S_L_MUL:   state_d = S_L_STORE;
			S_L_STORE: state_d = S_P_DIFF;
			S_P_DIFF:  state_d = S_P_MULG;
			S_P_MULG:  state_d = S_P_MULS;
			S_P_MULS:  state_d = S_P_ACCS;
			S_P_ACCS: begin
				j_d = j_last ? '0 : j_q + 1'b1;
				state_d = j_last ? S_T_SUM : S_P_DIFF;
			end
			S_T_SUM:   state_d = S_T_MUL1;
			S_T_MUL1:  state_d = S_T_MUL2;
			S_T_MUL2:  state_d = S_T_STORE;
			S_T_STORE: begin
				i_d = i_last ? '0 : i_q + 1'b1;
				state_d = i_last ? S_EMIT : S_L_DIFF;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					i_d = i_last ? '0 : i_q + 1'b1;
					if (i_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.i = i_q;
		cmd.j = j_q;
		item_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR:   cmd.op = OP_CLEAR;
			S_IDLE:    cmd.op = item_valid ? OP_ACCEPT : OP_NONE;
			S_G_DIFF:  cmd.op = OP_G_DIFF;
			S_G_MUL1:  cmd.op = OP_G_MUL1;
			S_G_ROM:   cmd.op = OP_G_ROM;
			S_G_MUL2:  cmd.op = OP_G_MUL2;
			S_G_STORE: cmd.op = OP_G_STORE;
			S_L_DIFF:  cmd.op = OP_L_DIFF;
			S_L_MUL:   cmd.op = OP_L_MUL;
			S_L_STORE: cmd.op = OP_L_STORE;
			S_P_DIFF:  cmd.op = OP_P_DIFF;
			S_P_MULG:  cmd.op = OP_P_MULG;
			S_P_MULS:  cmd.op = OP_P_MULS;
			S_P_ACCS:  cmd.op = OP_P_ACCS;
			S_T_SUM:   cmd.op = OP_T_SUM;
			S_T_MUL1:  cmd.op = OP_T_MUL1;
			S_T_MUL2:  cmd.op = OP_T_MUL2;
			S_T_STORE: cmd.op = OP_T_STORE;
			S_EMIT:    cmd.op = OP_EMIT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !sts.out_free |=> state_q == S_EMIT && $stable(i_q))
		else $error("emit advanced without output slot");
	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_T_STORE && i_last |=> state_q == S_EMIT && i_q == '0)
		else $error("emit phase not entered at neuron zero");
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && item_valid && action == ACT_TICK
		|=> state_q == S_G_DIFF && j_q == '0)
		else $error("tick did not start conductance pass");

endmodule

`default_nettype wire

### rtl/nne_dp.sv
// ----------------------------------------------------------------------------
// nne_dp
// Datapath: config registers, neuron stores, weight RAMs, shared multiplier,
// sigmoid ROM, accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nne_dp import nne_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic [2:0]           action,
	input  wire logic [3:0]           neuron,
	input  wire logic [3:0]           source,
	input  wire logic [7:0]           weight,
	input  wire logic [2:0]           param_select,
	input  wire logic signed [31:0]   value,
	input  wire logic signed [31:0]   stim_current,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [3:0]                neuron_index,
	output logic signed [31:0]        voltage,
	output logic                      last
);

	localparam sig_rom_t SIG_ROM = build_sig_rom();

	logic signed [31:0] gcond_q, gmax_q, leak_pot_q, slope_q;
	logic [30:0]        dt_q;

	logic signed [31:0] ir_q [NEURONS];
	logic signed [31:0] ic_q [NEURONS];
	logic signed [31:0] er_q [NEURONS];
	logic signed [31:0] mid_q [NEURONS];
	logic signed [31:0] iv_q [NEURONS];
	logic signed [31:0] volt_q [NEURONS];
	logic signed [31:0] delta_q [NEURONS];
	logic signed [31:0] cond_q [NEURONS];

	logic signed [31:0] vi_q, d_q, ds_q, s_q, leak_q, stim_q;
	logic [NIDX_W-1:0]  stim_idx_q;
	logic               stim_en_q;
	logic signed [63:0] prod_q;
	logic signed [ACC_W-1:0] gap_acc_q, syn_acc_q;
	logic               out_valid_q, out_last_q;
	logic [3:0]         out_idx_q;
	logic signed [31:0] out_v_q;

	logic accept, in_range;
	logic signed [31:0] mul_a, mul_b, prod_r, x_cl, new_v;
	logic [63:0] rom_t;
	logic [ROM_IDX_W-1:0] rom_idx;
	logic [WADDR_W-1:0] waddr;
	logic gap_we, syn_we;
	logic [7:0] wdata, gap_w, syn_w;
	logic signed [ACC_W-1:0] gap_term, syn_term;
	logic signed [63:0] tot;

	assign accept   = (cmd.op == OP_ACCEPT);
	assign in_range = (int'(neuron) < NEURONS) && (int'(source) < NEURONS);
	assign prod_r   = mulq_rnd(prod_q);
	assign sts.out_free = !out_valid_q || !result_stall;

	assign waddr  = accept ? {neuron[NIDX_W-1:0], source[NIDX_W-1:0]} : {cmd.i, cmd.j};
	assign wdata  = (cmd.op == OP_CLEAR) ? 8'd0 : weight;
	assign gap_we = (cmd.op == OP_CLEAR) || (accept && action == ACT_GAP && in_range);
	assign syn_we = (cmd.op == OP_CLEAR) || (accept && action == ACT_SYN && in_range);

	nne_ram #(.WIDTH(8), .DEPTH(NEURONS * NEURONS)) u_gap_ram (
		.clk(clk), .we(gap_we), .addr(waddr), .wdata(wdata), .rdata(gap_w)
	);
	nne_ram #(.WIDTH(8), .DEPTH(NEURONS * NEURONS)) u_syn_ram (
		.clk(clk), .we(syn_we), .addr(waddr), .wdata(wdata), .rdata(syn_w)
	);

	always_comb begin
		mul_a = d_q;
		mul_b = ir_q[cmd.i];
		case (cmd.op)
			OP_G_MUL1: begin mul_a = slope_q;     mul_b = d_q;            end
			OP_G_MUL2: begin mul_a = gmax_q;      mul_b = s_q;            end
			OP_P_MULG: begin mul_a = gcond_q;     mul_b = d_q;            end
			OP_P_MULS: begin mul_a = cond_q[cmd.j]; mul_b = ds_q;         end
			OP_T_MUL1: begin mul_a = d_q;         mul_b = ic_q[cmd.i];    end
			OP_T_MUL2: begin mul_a = prod_r;      mul_b = {1'b0, dt_q};   end
			default:   begin mul_a = d_q;         mul_b = ir_q[cmd.i];    end
		endcase
	end

	// sigmoid index: clamp to [-8,8], scale to table span, round
	always_comb begin
		x_cl = prod_r;
		if (prod_r > X_LIMIT)
			x_cl = X_LIMIT;
		else if (prod_r < -X_LIMIT)
			x_cl = -X_LIMIT;
		rom_t = (64'(x_cl + X_LIMIT) * 64'(EXP_TABLE_DEPTH - 1) + 64'd524288) >> 20;
		rom_idx = (rom_t >= 64'(EXP_TABLE_DEPTH)) ? ROM_IDX_W'(EXP_TABLE_DEPTH - 1)
			: rom_t[ROM_IDX_W-1:0];
	end

	assign gap_term = ACC_W'(signed'({1'b0, gap_w}) * prod_r);
	assign syn_term = ACC_W'(signed'({1'b0, syn_w}) * prod_r);
	assign tot = sx64(leak_q) + sx64(sat32(64'(gap_acc_q))) + sx64(sat32(64'(syn_acc_q)))
		+ ((stim_en_q && stim_idx_q == cmd.i) ? sx64(stim_q) : 64'sd0);
	assign new_v = sat32(sx64(volt_q[cmd.i]) + sx64(delta_q[cmd.i]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcond_q <= '0;
			gmax_q <= '0;
			leak_pot_q <= '0;
			slope_q <= '0;
			dt_q <= '0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < NEURONS; n++)
				volt_q[n] <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_GAP_COND:  gcond_q <= cfg_data;
					REG_SYN_GMAX:  gmax_q <= cfg_data;
					REG_LEAK_POT:  leak_pot_q <= cfg_data;
					REG_SIG_SLOPE: slope_q <= cfg_data;
					REG_TIME_STEP: dt_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (accept && action == ACT_RESTART)
				for (int n = 0; n < NEURONS; n++)
					volt_q[n] <= iv_q[n];
			if (cmd.op == OP_EMIT && sts.out_free) begin
				volt_q[cmd.i] <= new_v;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stim_q <= stim_current;
			stim_idx_q <= neuron[NIDX_W-1:0];
			stim_en_q <= (int'(neuron) < NEURONS);
			if (action == ACT_PARAM && int'(neuron) < NEURONS) begin
				case (param_select)
					PSEL_INV_RES:  ir_q[neuron[NIDX_W-1:0]] <= value;
					PSEL_INV_CAP:  ic_q[neuron[NIDX_W-1:0]] <= value;
					PSEL_REVERSAL: er_q[neuron[NIDX_W-1:0]] <= value;
					PSEL_MIDPOINT: mid_q[neuron[NIDX_W-1:0]] <= value;
					PSEL_INIT_V:   iv_q[neuron[NIDX_W-1:0]] <= value;
					default: ;
				endcase
			end
		end
		if (cmd.op inside {OP_G_MUL1, OP_G_MUL2, OP_L_MUL, OP_P_MULG, OP_P_MULS,
			OP_T_MUL1, OP_T_MUL2})
			prod_q <= sx64(mul_a) * sx64(mul_b);
		case (cmd.op)
			OP_G_DIFF:  d_q <= sat32(sx64(volt_q[cmd.j]) - sx64(mid_q[cmd.j]));
			OP_G_ROM:   s_q <= SIG_ROM[rom_idx];
			OP_G_STORE: cond_q[cmd.j] <= prod_r;
			OP_L_DIFF: begin
				vi_q <= volt_q[cmd.i];
				d_q <= sat32(sx64(leak_pot_q) - sx64(volt_q[cmd.i]));
			end
			OP_L_STORE: begin
				leak_q <= prod_r;
				gap_acc_q <= '0;
				syn_acc_q <= '0;
			end
			OP_P_DIFF: begin
				d_q <= sat32(sx64(volt_q[cmd.j]) - sx64(vi_q));
				ds_q <= sat32(sx64(er_q[cmd.j]) - sx64(vi_q));
			end
			OP_P_MULS:  gap_acc_q <= gap_acc_q + gap_term;
			OP_P_ACCS:  syn_acc_q <= syn_acc_q + syn_term;
			OP_T_SUM:   d_q <= sat32(tot);
			OP_T_STORE: delta_q[cmd.i] <= prod_r;
			OP_EMIT: begin
				if (sts.out_free) begin
					out_v_q <= new_v;
					out_idx_q <= 4'(cmd.i);
					out_last_q <= (cmd.i == NIDX_W'(NEURONS - 1));
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign neuron_index = out_idx_q;
	assign voltage      = out_v_q;
	assign last         = out_last_q;

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT && sts.out_free |=> result_valid)
		else $error("result register not loaded");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> neuron_index == 4'(NEURONS - 1))
		else $error("last flag on wrong neuron");
	a_volt_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT && sts.out_free |=> volt_q[$past(cmd.i)] == voltage)
		else $error("voltage store and result disagree");

endmodule

`default_nettype wire

### rtl/neuron_network_euler_step_top.sv
// Tick: accepted when idle, then a conductance pass over all neurons and, per
// neuron, leak, pair and total passes; the first result is registered after
// that, then one per cycle while the output is not stalled. The input stalls
// after a tick until the last result is registered, so ticks never overlap; the
// shared multiplier sets this. Loads and restart are taken when idle; config
// writes are always ready. After reset a sweep zeroes both weight RAMs (items stall); voltages, regs zero.
// ----------------------------------------------------------------------------
// neuron_network_euler_step_top
// Top level: sequencer plus datapath of the leaky integrator network.
// ----------------------------------------------------------------------------
`default_nettype none

module neuron_network_euler_step_top import nne_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [2:0]           action,
	input  wire logic [3:0]           neuron,
	input  wire logic [3:0]           source,
	input  wire logic [7:0]           weight,
	input  wire logic [2:0]           param_select,
	input  wire logic signed [31:0]   value,
	input  wire logic signed [31:0]   stim_current,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [3:0]                neuron_index,
	output logic signed [31:0]        voltage,
	output logic                      last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	nne_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .action(action),
		.item_stall(item_stall), .cmd(cmd), .sts(sts)
	);

	nne_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(action), .neuron(neuron), .source(source), .weight(weight),
		.param_select(param_select), .value(value), .stim_current(stim_current),
		.result_valid(result_valid), .result_stall(result_stall),
		.neuron_index(neuron_index), .voltage(voltage), .last(last)
	);

endmodule

`default_nettype wire

### dv/neuron_network_euler_step_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neuron_network_euler_step_top_tb
// Self-checking bench for the neuron network Euler step block. A queue-fed
// driver sends weight loads, parameter loads, restarts and ticks. A local
// fixed-point network model predicts each tick's voltages, and a monitor
// checks them in order. Register settings and idling patterns change per phase.
// ----------------------------------------------------------------------------
module neuron_network_euler_step_top_tb;
	import nne_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [2:0]         act;
		logic [3:0]         nrn;
		logic [3:0]         src;
		logic [7:0]         wt;
		logic [2:0]         psel;
		logic signed [31:0] val;
		logic signed [31:0] stim;
	} net_req_t;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] volt;
		logic               lst;
	} volt_rsp_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic item_valid, item_stall;
	logic [2:0] action, param_select;
	logic [3:0] neuron, source;
	logic [7:0] weight;
	logic signed [31:0] value, stim_current;
	logic result_valid, result_stall;
	logic [3:0] neuron_index;
	logic signed [31:0] voltage;
	logic last;

	neuron_network_euler_step_top uut (.*);

	// network model state
	logic [7:0]         gap_w [NEURONS*NEURONS];
	logic [7:0]         syn_w [NEURONS*NEURONS];
	logic signed [31:0] inv_r [NEURONS], inv_c [NEURONS], rev_e [NEURONS];
	logic signed [31:0] mid_v [NEURONS], init_v [NEURONS], mem_v [NEURONS];
	logic signed [31:0] g_gap, g_syn, e_leak, slope, tstep;
	logic [31:0]        sig_tab [EXP_TABLE_DEPTH];

	net_req_t  pending_reqs [$];
	volt_rsp_t expected_volts [$];
	net_req_t  cur_req;
	int mode, errors, ticks, checked;
	logic rst_done, hold_req, hold_done;
	int hold_left, idle_cnt;

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip32((p + 32768) >>> 16);
	endfunction

	task automatic fill_sig_tab();
		longint x;
		longint unsigned y, f, sum, term, den, num;
		int n;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			x = -524288 + (longint'(1048576) * k) / (EXP_TABLE_DEPTH - 1);
			y = (x < 0) ? -x : x;
			f = (y & 64'hffff) << 16;
			n = int'((y >> 16) & 15);
			sum = 64'd1 << 32;
			term = 64'd1 << 32;
			for (int t = 1; t <= 13; t++) begin
				term = ((term * f) >> 32) / t;
				if (t % 2) sum = sum - term; else sum = sum + term;
			end
			for (int m = 0; m < n; m++)
				sum = (sum * 64'd1580030169) >> 32;
			den = (64'd1 << 32) + sum;
			num = (x >= 0) ? (sum << 16) : (64'd1 << 48);
			sig_tab[k] = 32'((num + den / 2) / den);
		end
	endtask

	function automatic logic signed [31:0] sig_of(logic signed [31:0] xin);
		longint x, idx;
		x = xin;
		if (x > 524288) x = 524288;
		if (x < -524288) x = -524288;
		idx = ((x + 524288) * (EXP_TABLE_DEPTH - 1) + 524288) >>> 20;
		if (idx > EXP_TABLE_DEPTH - 1) idx = EXP_TABLE_DEPTH - 1;
		return sig_tab[idx];
	endfunction

	task automatic predict_request(net_req_t r);
		logic signed [31:0] cond [NEURONS];
		logic signed [31:0] dlt [NEURONS];
		logic signed [31:0] vi, leak, gt, st;
		longint gsum, ssum, tot;
		volt_rsp_t rsp;
		case (r.act)
			ACT_GAP: gap_w[{r.nrn, r.src}] = r.wt;
			ACT_SYN: syn_w[{r.nrn, r.src}] = r.wt;
			ACT_PARAM: case (r.psel)
				PSEL_INV_RES:  inv_r[r.nrn] = r.val;
				PSEL_INV_CAP:  inv_c[r.nrn] = r.val;
				PSEL_REVERSAL: rev_e[r.nrn] = r.val;
				PSEL_MIDPOINT: mid_v[r.nrn] = r.val;
				PSEL_INIT_V:   init_v[r.nrn] = r.val;
				default: ;
			endcase
			ACT_RESTART: mem_v = init_v;
			ACT_TICK: begin
				ticks++;
				for (int j = 0; j < NEURONS; j++)
					cond[j] = qmul(g_syn,
						sig_of(qmul(slope, clip32(longint'(mem_v[j]) - mid_v[j]))));
				for (int i = 0; i < NEURONS; i++) begin
					vi = mem_v[i];
					leak = qmul(clip32(longint'(e_leak) - vi), inv_r[i]);
					gsum = 0;
					ssum = 0;
					for (int j = 0; j < NEURONS; j++) begin
						gt = qmul(g_gap, clip32(longint'(mem_v[j]) - vi));
						st = qmul(cond[j], clip32(longint'(rev_e[j]) - vi));
						gsum += longint'(gap_w[i*NEURONS+j]) * longint'(gt);
						ssum += longint'(syn_w[i*NEURONS+j]) * longint'(st);
					end
					tot = longint'(leak) + clip32(gsum) + clip32(ssum)
						+ ((i == r.nrn) ? longint'(r.stim) : 0);
					dlt[i] = qmul(qmul(clip32(tot), inv_c[i]), tstep);
				end
				for (int i = 0; i < NEURONS; i++) begin
					mem_v[i] = clip32(longint'(mem_v[i]) + dlt[i]);
					rsp.idx = i;
					rsp.volt = mem_v[i];
					rsp.lst = (i == NEURONS - 1);
					expected_volts.push_back(rsp);
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (item_valid && !item_stall)
			predict_request(cur_req);
		if (!item_valid || !item_stall) begin
			if (rst_done && pending_reqs.size() > 0 && !((mode == 1 && chance(63)) ||
					(mode == 3 && chance(8)))) begin
				cur_req = pending_reqs.pop_front();
				action <= cur_req.act;
				neuron <= cur_req.nrn;
				source <= cur_req.src;
				weight <= cur_req.wt;
				param_select <= cur_req.psel;
				value <= cur_req.val;
				stim_current <= cur_req.stim;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (mode == 2) ? chance(63) : (mode == 3) ? chance(8) : 1'b0;
		end
	end

	// voltage monitor
	always @(posedge clk) begin
		volt_rsp_t e;
		if (result_valid && !result_stall) begin
			if (expected_volts.size() == 0) begin
				$error("unexpected result: neuron_index %0d voltage %0d", neuron_index, voltage);
				errors++;
			end else begin
				e = expected_volts.pop_front();
				checked++;
				if (neuron_index !== e.idx) begin
					$error("neuron_index: expected %0d actual %0d", e.idx, neuron_index);
					errors++;
				end
				if (voltage !== e.volt) begin
					$error("voltage: expected %0d actual %0d", e.volt, voltage);
					errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d actual %0d", e.lst, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// valid stays high across back-to-back writes; set_regs drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAP_COND:  g_gap = data;
			REG_SYN_GMAX:  g_syn = data;
			REG_LEAK_POT:  e_leak = data;
			REG_SIG_SLOPE: slope = data;
			REG_TIME_STEP: tstep = {1'b0, data[30:0]};
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] gg, logic [31:0] gs, logic [31:0] el,
			logic [31:0] sl, logic [31:0] ts);
		write_reg(REG_GAP_COND, gg);
		write_reg(REG_SYN_GMAX, gs);
		write_reg(REG_LEAK_POT, el);
		write_reg(REG_SIG_SLOPE, sl);
		write_reg(REG_TIME_STEP, ts);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_req(logic [2:0] a, logic [3:0] n, logic [3:0] s, logic [7:0] w,
			logic [2:0] p, logic [31:0] v, logic [31:0] st);
		net_req_t r;
		r.act = a; r.nrn = n; r.src = s; r.wt = w; r.psel = p; r.val = v; r.stim = st;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [31:0] mid_rand();
		return $urandom_range(32'h100000) - 32'h80000;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || item_valid || expected_volts.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_random(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 35)
				push_req(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
					chance(30) ? $urandom : mid_rand());
			else if (r < 55)
				push_req(ACT_PARAM, $urandom, $urandom, $urandom, $urandom_range(4),
					chance(20) ? $urandom : mid_rand(), $urandom);
			else if (r < 80)
				push_req(chance(50) ? ACT_GAP : ACT_SYN, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			else if (r < 88)
				push_req(ACT_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else if (r < 94)
				push_req(ACT_PARAM, $urandom, $urandom, $urandom, $urandom_range(7, 5),
					$urandom, $urandom);
			else
				push_req($urandom_range(7, 5), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
		end
	endtask

	initial begin
		fill_sig_tab();
		foreach (gap_w[k]) begin
			gap_w[k] = 0;
			syn_w[k] = 0;
		end
		foreach (mem_v[k]) mem_v[k] = 0;
		{g_gap, g_syn, e_leak, slope, tstep} = '0;
		errors = 0; ticks = 0; checked = 0; mode = 0; idle_cnt = 0;
		rst_done = 0; hold_req = 0; hold_done = 0; hold_left = 0;
		arst_n = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		item_valid = 0; result_stall = 0;
		action = '0; neuron = '0; source = '0; weight = '0; param_select = '0;
		value = '0; stim_current = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(32'h1000, 32'h2000, 32'hfffc0000, 32'h8000, 32'h1000);
		rst_done = 1;

		// every neuron parameter is loaded before the first restart or tick
		for (int n = 0; n < NEURONS; n++) begin
			push_req(ACT_PARAM, n, 0, 0, PSEL_INV_RES, $urandom_range(32'h4000), 0);
			push_req(ACT_PARAM, n, 0, 0, PSEL_INV_CAP, $urandom_range(32'h20000), 0);
			push_req(ACT_PARAM, n, 0, 0, PSEL_REVERSAL, mid_rand(), 0);
			push_req(ACT_PARAM, n, 0, 0, PSEL_MIDPOINT, mid_rand(), 0);
			push_req(ACT_PARAM, n, 0, 0, PSEL_INIT_V, mid_rand(), 0);
		end
		// directed corners
		push_req(ACT_GAP, 0, 0, 8'hff, 0, 0, 0);
		push_req(ACT_GAP, 15, 15, 8'hff, 0, 0, 0);
		push_req(ACT_SYN, 15, 0, 8'hff, 0, 0, 0);
		push_req(ACT_SYN, 0, 15, 8'h01, 0, 0, 0);
		push_req(ACT_GAP, 3, 7, 8'h00, 0, 0, 0);
		push_req(ACT_RESTART, 0, 0, 0, 0, 0, 0);
		push_req(ACT_TICK, 0, 0, 0, 0, 0, 32'h7fffffff);
		push_req(ACT_TICK, 15, 0, 0, 0, 0, 32'h80000000);
		push_req(ACT_PARAM, 5, 0, 0, 3'd5, 32'h7fffffff, 0);
		push_req(ACT_PARAM, 5, 0, 0, 3'd7, 32'h80000000, 0);
		push_req(3'd5, 1, 2, 3, 0, 0, 0);
		push_req(3'd6, 1, 2, 3, 0, 0, 0);
		push_req(3'd7, 15, 15, 8'hff, 3'd7, 32'hffffffff, 32'hffffffff);
		push_req(ACT_PARAM, 2, 0, 0, PSEL_REVERSAL, 32'h7fffffff, 0);
		push_req(ACT_PARAM, 9, 0, 0, PSEL_INIT_V, 32'h80000000, 0);
		push_req(ACT_PARAM, 4, 0, 0, PSEL_INV_CAP, 32'h80000000, 0);
		push_req(ACT_RESTART, 0, 0, 0, 0, 0, 0);
		push_req(ACT_TICK, 2, 0, 0, 0, 0, 32'h00010000);
		push_req(ACT_TICK, 9, 0, 0, 0, 0, 0);
		push_req(ACT_PARAM, 2, 0, 0, PSEL_REVERSAL, 32'h00010000, 0);
		push_req(ACT_PARAM, 9, 0, 0, PSEL_INIT_V, 0, 0);
		push_req(ACT_PARAM, 4, 0, 0, PSEL_INV_CAP, 32'h10000, 0);
		push_req(ACT_RESTART, 0, 0, 0, 0, 0, 0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1: set_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff);
				2: set_regs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
				3: set_regs(32'h3000, 32'hffff8000, 32'h20000, 32'hfffe0000, 32'h800);
				default: ;
			endcase
			mode = ph;
			push_req(ACT_RESTART, 0, 0, 0, 0, 0, 0);
			add_random(82);
			if (ph == 0) hold_req = 1;
			wait_drained();
		end
		repeat (50) @(posedge clk);

		$display("Covered %0d ticks, %0d voltages checked, over 4 register settings",
			ticks, checked);
		$display("and idling modes: none, sender idle, receiver stall, both sides.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
